// ===== hdl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared widths, register indexes, layout codes and the per-axis settings
// bundle of the detector pixel position block.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int DPP_INDEX_BITS = 12;

  // field widths
  localparam int COL_W      = 12;
  localparam int SIZE_W     = 20;
  localparam int MSIZE_W    = 13;
  localparam int GAP_W      = 8;
  localparam int MAG_W      = 44;
  localparam int POS_W      = 45;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;

  // effective module size: 0 stands for 8192
  localparam logic [MSIZE_W:0] MSIZE_ZERO = 14'd8192;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_WIDTH       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_HEIGHT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_VERTICAL = 3'd6;

  // layout codes; the unused code behaves as the plain grid
  localparam logic [1:0] LAYOUT_PLAIN = 2'd0;
  localparam logic [1:0] LAYOUT_TILED = 2'd1;
  localparam logic [1:0] LAYOUT_CHIP  = 2'd2;

  // settings seen by one axis lane
  typedef struct packed {
    logic [1:0]         mode;
    logic [SIZE_W-1:0]  size;
    logic [MSIZE_W:0]   msize;
    logic [GAP_W-1:0]   gap;
  } lane_cfg_t;

endpackage

// ===== hdl/dpp_lane.sv =====
// ----------------------------------------------------------------------------
// dpp_lane
// One axis lane: pipelined restoring divide of the index by the module size,
// layout offset in quarter pixels, scale by the pixel pitch, saturation.
// ----------------------------------------------------------------------------
module dpp_lane
  import dpp_pkg::*;
#(
  parameter int INDEX_BITS = DPP_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  en,
  input  lane_cfg_t             cfg,
  input  logic [INDEX_BITS-1:0] idx,
  output logic [MAG_W-1:0]      mag
);

  localparam int IB = INDEX_BITS;
  localparam int KW = IB + 11;
  localparam int PW = KW + SIZE_W;

  logic [IB-1:0]      idx_q [IB];
  logic [IB-1:0]      quo_q [IB];
  logic [MSIZE_W-1:0] rem_q [IB];

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < IB; j++) begin : g_div
    logic [IB-1:0]      idx_in;
    logic [IB-1:0]      quo_in;
    logic [MSIZE_W-1:0] rem_in;
    logic [MSIZE_W:0]   trial;
    logic [MSIZE_W:0]   diff;
    logic               ge;

    if (j == 0) begin : g_first
      assign idx_in = idx;
      assign quo_in = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign idx_in = idx_q[j-1];
      assign quo_in = quo_q[j-1];
      assign rem_in = rem_q[j-1];
    end

    assign trial = {rem_in, idx_in[IB-1-j]};
    assign ge    = (trial >= cfg.msize);
    assign diff  = trial - cfg.msize;

    always_ff @(posedge clk) begin
      if (en) begin
        idx_q[j] <= idx_in;
        quo_q[j] <= {quo_in[IB-2:0], ge};
        rem_q[j] <= ge ? diff[MSIZE_W-1:0] : trial[MSIZE_W-1:0];
      end
    end
  end

  logic [IB-1:0]      i_v;
  logic [IB-1:0]      q_v;
  logic [MSIZE_W-1:0] r_v;
  logic [IB+7:0]      qg;
  logic [IB+8:0]      tiled_sum;
  logic [IB+1:0]      chip_sum;
  logic [IB+3:0]      chip_base;
  logic [MSIZE_W:0]   r_plus2;
  logic [KW-1:0]      k_next;
  logic [KW-1:0]      k;
  logic [PW-1:0]      prod;
  logic [PW+MAG_W-1:0] prod_x;

  assign i_v = idx_q[IB-1];
  assign q_v = quo_q[IB-1];
  assign r_v = rem_q[IB-1];

  assign qg        = (IB+8)'(q_v) * (IB+8)'(cfg.gap);
  assign tiled_sum = {9'd0, i_v} + {1'b0, qg};
  assign chip_sum  = {2'd0, i_v} + {2'd0, q_v} + {1'b0, q_v, 1'b0};
  assign chip_base = {chip_sum, 2'b00};
  assign r_plus2   = {1'b0, r_v} + (MSIZE_W+1)'(2);

  always_comb begin
    case (cfg.mode)
      LAYOUT_TILED: k_next = {tiled_sum, 2'b10};
      LAYOUT_CHIP: begin
        if (i_v == IB'(0))
          k_next = KW'(2);
        else if (i_v == IB'(1))
          k_next = KW'(6);
        else if (r_v == '0)
          k_next = KW'(chip_base) - KW'(1);
        else if (r_plus2 <= cfg.msize)
          k_next = KW'(chip_base) + KW'(2);
        else
          k_next = KW'(chip_base) + KW'(10);
      end
      default: k_next = KW'({i_v, 2'b10});
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k    <= k_next;
      prod <= PW'(k) * PW'(cfg.size);
    end
  end

  // clamp the magnitude to the largest positive output value
  assign prod_x = {{MAG_W{1'b0}}, prod};
  assign mag    = (|prod_x[PW+MAG_W-1:MAG_W]) ? '1 : prod_x[MAG_W-1:0];

endmodule

// ===== hdl/dpp_merge.sv =====
// ----------------------------------------------------------------------------
// dpp_merge
// Joins the two lane magnitudes, applies the signs and holds the result in
// an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module dpp_merge
  import dpp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MAG_W-1:0]      ymag,
  input  logic [MAG_W-1:0]      zmag,
  input  logic                  mirror,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic [POS_W-1:0]      hpos;
  logic [POS_W-1:0]      zpos;
  logic [POS_W-1:0]      vpos;
  logic [OUT_DATA_W-1:0] beat;
  logic [OUT_DATA_W-1:0] out_data;
  logic [OUT_DATA_W-1:0] skid_data;
  logic                  out_valid;
  logic                  skid_valid;
  logic                  load;
  logic                  take;

  assign hpos = POS_W'(0) - {1'b0, ymag};
  assign zpos = {1'b0, zmag};
  assign vpos = mirror ? (POS_W'(0) - zpos) : zpos;
  assign beat = {{(OUT_DATA_W-2*POS_W){1'b0}}, vpos, hpos};

  assign in_ready = !skid_valid;
  assign load     = in_valid && in_ready;
  assign take     = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take && skid_valid) begin
      // drain the skid entry first
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (!out_valid || take)
        out_valid <= 1'b1;
      else
        skid_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid)
      out_data <= skid_data;
    else if (load && (!out_valid || take))
      out_data <= beat;
    if (load && out_valid && !take)
      skid_data <= beat;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== hdl/detector_pixel_position.sv =====
// ----------------------------------------------------------------------------
// detector_pixel_position
// Pixel column and line in, physical -y and z pixel-center positions out.
// ----------------------------------------------------------------------------
// One pixel is taken every clock. The divide of the index by the module
// size registers each quotient bit, then the layout offset, the
// pixel-pitch product and the signed output are registered. The column and
// line run in two identical lanes side by side. Positions are in quarters
// of the pitch unit, 45-bit two's complement, with magnitudes clamped at
// 2^44-1. With a stalled output the pipeline holds once the skid entry is
// full. The user must write registers through the cfg port only while no
// pixel is in flight; the block itself does not enforce this.
module detector_pixel_position
  import dpp_pkg::*;
#(
  parameter int INDEX_BITS = DPP_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] column, [23:12] line
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [44:0] horizontal_pos,
                                           // [89:45] vertical_pos, zero above
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LAT = INDEX_BITS + 2;

  logic [1:0]          layout_mode;
  logic [SIZE_W-1:0]   pitch;
  logic [MSIZE_W-1:0]  mod_cols;
  logic [MSIZE_W-1:0]  mod_rows;
  logic [GAP_W-1:0]    gap_cols;
  logic [GAP_W-1:0]    gap_rows;
  logic                mirror_vertical;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode     <= LAYOUT_PLAIN;
      pitch           <= SIZE_W'(1);
      mod_cols        <= MSIZE_W'(256);
      mod_rows        <= MSIZE_W'(256);
      gap_cols        <= '0;
      gap_rows        <= '0;
      mirror_vertical <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LAYOUT_MODE:     layout_mode     <= cfg_wdata[1:0];
        REG_PIXEL_SIZE:      pitch           <= cfg_wdata[SIZE_W-1:0];
        REG_MODULE_WIDTH:    mod_cols        <= cfg_wdata[MSIZE_W-1:0];
        REG_MODULE_HEIGHT:   mod_rows        <= cfg_wdata[MSIZE_W-1:0];
        REG_GAP_WIDTH:       gap_cols        <= cfg_wdata[GAP_W-1:0];
        REG_GAP_HEIGHT:      gap_rows        <= cfg_wdata[GAP_W-1:0];
        REG_MIRROR_VERTICAL: mirror_vertical <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  lane_cfg_t y_cfg;
  lane_cfg_t z_cfg;

  assign y_cfg.mode  = layout_mode;
  assign y_cfg.size  = pitch;
  assign y_cfg.msize = (mod_cols == '0) ? MSIZE_ZERO : {1'b0, mod_cols};
  assign y_cfg.gap   = gap_cols;
  assign z_cfg.mode  = layout_mode;
  assign z_cfg.size  = pitch;
  assign z_cfg.msize = (mod_rows == '0) ? MSIZE_ZERO : {1'b0, mod_rows};
  assign z_cfg.gap   = gap_rows;

  // reduce each index to INDEX_BITS, zero-extending when wider
  logic [COL_W+INDEX_BITS-1:0] col_x;
  logic [COL_W+INDEX_BITS-1:0] lin_x;

  assign col_x = {{INDEX_BITS{1'b0}}, s_tdata[COL_W-1:0]};
  assign lin_x = {{INDEX_BITS{1'b0}}, s_tdata[2*COL_W-1:COL_W]};

  logic           en;
  logic [LAT-1:0] vld;
  logic [MAG_W-1:0] ymag;
  logic [MAG_W-1:0] zmag;

  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst)
      vld <= '0;
    else if (en)
      vld <= {vld[LAT-2:0], s_tvalid};
  end

  dpp_lane #(.INDEX_BITS(INDEX_BITS)) u_lane_y (
    .clk (clk),
    .en  (en),
    .cfg (y_cfg),
    .idx (col_x[INDEX_BITS-1:0]),
    .mag (ymag)
  );

  dpp_lane #(.INDEX_BITS(INDEX_BITS)) u_lane_z (
    .clk (clk),
    .en  (en),
    .cfg (z_cfg),
    .idx (lin_x[INDEX_BITS-1:0]),
    .mag (zmag)
  );

  dpp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[LAT-1]),
    .in_ready (en),
    .ymag     (ymag),
    .zmag     (zmag),
    .mirror   (mirror_vertical),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hdl/dpp_checker.sv =====
// ----------------------------------------------------------------------------
// dpp_checker
// Port-level checks on the detector pixel position block, bound to the top.
// ----------------------------------------------------------------------------
module dpp_checker
  import dpp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // an empty output stage means the skid entry is empty too
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // -y never positive and never below the negative clamp value
  a_hpos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[POS_W-1] || (m_tdata[POS_W-1:0] == '0)) &&
                  (m_tdata[POS_W-1:0] != {1'b1, {(POS_W-1){1'b0}}})))
    else $error("horizontal position out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1:2*POS_W] == '0))
    else $error("padding bits set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled beat changed");

endmodule

bind detector_pixel_position dpp_checker u_dpp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
